// ----- hdl/pti_pkg.sv -----
// ----------------------------------------------------------------------------
// pti_pkg
// Shared types and constants for the timestamped pose interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

    localparam int STORE_DEPTH         = 256;
    localparam int RATIO_FRACTION_BITS = 16;
    localparam int STAMP_W             = 48;
    localparam int POS_W               = 32;
    localparam int HEAD_W              = 16;
    localparam int CFG_W               = 32;
    localparam int CNT_W               = $clog2(STORE_DEPTH + 2);
    localparam int RATIO_W             = RATIO_FRACTION_BITS + 1;

    localparam logic [CFG_W-1:0] HISTORY_RESET = 32'd5000000;
    localparam logic [CFG_W-1:0] TOL_RESET     = 32'd100000;

    localparam logic REG_HISTORY = 1'b0;
    localparam logic REG_TOL     = 1'b1;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic        [STAMP_W-1:0] stamp;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [HEAD_W-1:0]  heading;
    } sample_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PRUNE,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

endpackage

// ----- hdl/pti_cell.sv -----
// ----------------------------------------------------------------------------
// pti_cell
// One sample slot of the rotating store; takes its neighbor's sample on shift.
// ----------------------------------------------------------------------------
module pti_cell
    import pti_pkg::*;
(
    input  logic    clk,
    input  logic    shift,
    input  sample_t d,
    output sample_t q
);

    sample_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ----- hdl/pti_ratio.sv -----
// ----------------------------------------------------------------------------
// pti_ratio
// Restoring divider: floor(num * 2^F / den), saturated to 1.0 when num >= den; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pti_ratio
    import pti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [STAMP_W-1:0] num,
    input  logic [STAMP_W-1:0] den,
    output logic [RATIO_W-1:0] ratio,
    output div_status_t        status
);

    localparam int ITER_W = $clog2(RATIO_FRACTION_BITS + 1);

    logic [STAMP_W:0]   rem_reg;
    logic [STAMP_W-1:0] den_reg;
    logic [RATIO_W-1:0] q_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [STAMP_W:0]   rem_sh;

    assign rem_sh = {rem_reg[STAMP_W-1:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (num >= den)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    iter_reg <= ITER_W'(RATIO_FRACTION_BITS);
                end
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= {1'b0, num};
            q_reg   <= (num >= den) ? (RATIO_W'(1) << RATIO_FRACTION_BITS) : '0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                q_reg   <= {q_reg[RATIO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[RATIO_W-2:0], 1'b0};
            end
        end
    end

    assign ratio       = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- hdl/timestamped_pose_interpolator.sv -----
// ----------------------------------------------------------------------------
// timestamped_pose_interpolator
// Ring of sample cells rotated past a read point at cells 0 and 1; pushes, pruning and
// query walks all happen as the ring turns.
// ----------------------------------------------------------------------------
// Push: a full turn of the cell ring inserts the sample (dropping the oldest when
//   full), then each pruned sample turns the ring by one more cell.
// Query: a full scan turn of the ring (none when empty), decide, then divider,
//   multiply and sum when it interpolates, then out.
// One word in flight at a time. Reset empties the store (count zero) and
//   loads the register defaults; cell contents are undefined, no clear pass.
// ----------------------------------------------------------------------------
module timestamped_pose_interpolator
    import pti_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [STAMP_W-1:0]       stamp,
    input  logic signed [POS_W-1:0]  pose_x,
    input  logic signed [POS_W-1:0]  pose_y,
    input  logic signed [HEAD_W-1:0] pose_heading,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     found,
    output logic signed [POS_W-1:0]  out_x,
    output logic signed [POS_W-1:0]  out_y,
    output logic signed [HEAD_W-1:0] out_heading,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int PX_W = RATIO_W + 1 + POS_W + 1;
    localparam int PH_W = RATIO_W + 1 + HEAD_W;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CFG_W-1:0]   window_reg, tol_reg;
    logic               cmd_reg;
    sample_t            in_reg;
    sample_t            front_reg, back_reg, os_reg, ns_reg;
    logic               hit_reg;
    logic               shift, inject, div_start, accept, full;
    logic               prunable, dec_interp, dec_found, walk_hit;
    sample_t            dec_pose;
    sample_t            cell_d [STORE_DEPTH];
    sample_t            cell_q [STORE_DEPTH];
    logic [RATIO_W-1:0] ratio;
    div_status_t        div_status;
    logic signed [PX_W-1:0]   prod_x_reg, prod_y_reg, shx, shy;
    logic signed [PH_W-1:0]   prod_h_reg, shh;
    logic signed [POS_W:0]    dx, dy;
    logic signed [HEAD_W-1:0] dh;
    logic                     res_found_reg, out_valid_reg, out_found_reg;
    sample_t                  res_reg;
    logic signed [POS_W-1:0]  out_x_reg, out_y_reg;
    logic signed [HEAD_W-1:0] out_h_reg;

    // cell ring: each cell takes its upper neighbor, the top one wraps or injects
    genvar j;
    generate
        for (j = 0; j < STORE_DEPTH; j++)
        begin : g_cell
            if (j == STORE_DEPTH - 1)
            begin : g_top
                assign cell_d[j] = inject ? in_reg : cell_q[0];
            end
            else
            begin : g_mid
                assign cell_d[j] = cell_q[j+1];
            end
            pti_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (cell_d[j]),
                .q     (cell_q[j])
            );
        end
    endgenerate

    pti_ratio u_ratio (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (in_reg.stamp - os_reg.stamp),
        .den    (ns_reg.stamp - os_reg.stamp),
        .ratio  (ratio),
        .status (div_status)
    );

    assign full     = (count_reg == CNT_W'(STORE_DEPTH));
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign prunable = (count_reg != '0) && (in_reg.stamp > cell_q[0].stamp)
                   && ((in_reg.stamp - cell_q[0].stamp) > {16'd0, window_reg});
    assign walk_hit = !hit_reg && (step_reg < count_reg - 1'b1)
                   && (in_reg.stamp <= cell_q[1].stamp);

    always_comb
    begin
        dec_interp = 1'b0;
        dec_found  = 1'b0;
        dec_pose   = '0;
        if (count_reg == '0)
        begin
            dec_found = 1'b0;
        end
        else if (in_reg.stamp <= front_reg.stamp)
        begin
            dec_found = (front_reg.stamp - in_reg.stamp) <= {16'd0, tol_reg};
            dec_pose  = front_reg;
        end
        else if (in_reg.stamp >= back_reg.stamp)
        begin
            dec_found = (in_reg.stamp - back_reg.stamp) <= {16'd0, tol_reg};
            dec_pose  = back_reg;
        end
        else if (hit_reg)
        begin
            if (ns_reg.stamp <= os_reg.stamp || in_reg.stamp <= os_reg.stamp)
            begin
                dec_found = 1'b1;
                dec_pose  = ns_reg;
            end
            else
            begin
                dec_interp = 1'b1;
            end
        end
        if (!dec_found)
        begin
            dec_pose = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        shift      = 1'b0;
        inject     = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    if (command == CMD_PUSH)
                        state_next = ST_INSERT;
                    else if (count_reg == '0)
                        state_next = ST_DECIDE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_INSERT:
            begin
                shift     = 1'b1;
                inject    = full ? (step_reg == '0) : (step_reg == count_reg);
                step_next = step_reg + 1'b1;
                if (full ? (step_reg == CNT_W'(STORE_DEPTH))
                         : (step_reg == CNT_W'(STORE_DEPTH - 1)))
                begin
                    state_next = ST_PRUNE;
                    count_next = full ? count_reg : count_reg + 1'b1;
                end
            end
            ST_PRUNE:
            begin
                if (prunable)
                begin
                    shift      = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                shift     = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(STORE_DEPTH - 1))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (dec_interp)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            window_reg    <= HISTORY_RESET;
            tol_reg       <= TOL_RESET;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_HISTORY)
                    window_reg <= cfg_data;
                else
                    tol_reg <= cfg_data;
            end
            if (accept)
                hit_reg <= 1'b0;
            else if (state_reg == ST_SCAN && walk_hit)
                hit_reg <= 1'b1;
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign dx = {ns_reg.x[POS_W-1], ns_reg.x} - {os_reg.x[POS_W-1], os_reg.x};
    assign dy = {ns_reg.y[POS_W-1], ns_reg.y} - {os_reg.y[POS_W-1], os_reg.y};
    assign dh = ns_reg.heading - os_reg.heading;
    assign shx = prod_x_reg >>> RATIO_FRACTION_BITS;
    assign shy = prod_y_reg >>> RATIO_FRACTION_BITS;
    assign shh = prod_h_reg >>> RATIO_FRACTION_BITS;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg            <= command;
            in_reg.stamp       <= stamp;
            in_reg.x           <= pose_x;
            in_reg.y           <= pose_y;
            in_reg.heading     <= pose_heading;
        end
        if (state_reg == ST_SCAN)
        begin
            if (step_reg == '0)
                front_reg <= cell_q[0];
            if (step_reg == count_reg - 1'b1)
                back_reg <= cell_q[0];
            if (walk_hit)
            begin
                os_reg <= cell_q[0];
                ns_reg <= cell_q[1];
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            res_found_reg <= dec_found;
            res_reg       <= dec_pose;
        end
        if (state_reg == ST_MUL)
        begin
            prod_x_reg <= $signed({1'b0, ratio}) * dx;
            prod_y_reg <= $signed({1'b0, ratio}) * dy;
            prod_h_reg <= $signed({1'b0, ratio}) * dh;
        end
        if (state_reg == ST_SUM)
        begin
            res_found_reg   <= 1'b1;
            res_reg.x       <= os_reg.x + shx[POS_W-1:0];
            res_reg.y       <= os_reg.y + shy[POS_W-1:0];
            res_reg.heading <= os_reg.heading + shh[HEAD_W-1:0];
        end
        if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
        begin
            out_found_reg <= res_found_reg;
            out_x_reg     <= res_reg.x;
            out_y_reg     <= res_reg.y;
            out_h_reg     <= res_reg.heading;
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_heading = out_h_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("sample count beyond store depth");

    a_push_inserts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_PUSH) |=> state_reg == ST_INSERT)
        else $error("push word did not start insert");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (out_x == '0 && out_y == '0 && out_heading == '0))
        else $error("miss result carries nonzero pose");

    a_push_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRUNE) |-> cmd_reg == CMD_PUSH)
        else $error("pruning during a query");

endmodule
